// File: hdl/ipp_pkg.sv
package ipp_pkg;

  // text bytes that the parser knows
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  // address geometry
  localparam int unsigned NumBytes     = 16;
  localparam logic [4:0]  FullPos      = 5'(NumBytes);
  localparam logic [4:0]  GroupLastPos = 5'(NumBytes - 2);
  localparam logic [4:0]  TailLastPos  = 5'(NumBytes - 4);
  localparam logic [2:0]  MaxOctets    = 3'd4;

  // family codes; any code with the upper bit set is unsupported
  localparam logic [1:0] FamIpv4 = 2'd0;
  localparam logic [1:0] FamIpv6 = 2'd1;

  typedef enum logic [1:0] {
    PhStart      = 2'd0,
    PhLead       = 2'd1,
    PhBody       = 2'd2,
    PhGroupColon = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusMalformed   = 2'd1,
    StatusUnsupported = 2'd2
  } status_e;

  // element [i] is address byte i
  typedef logic [NumBytes-1:0][7:0] addr_bytes_t;

  // dotted decimal token state
  typedef struct packed {
    logic [7:0] accum;
    logic [2:0] count;
    logic       seen;
    logic       dec_ok;
  } token_t;

  localparam token_t TokenReset = '{accum: 8'd0, count: 3'd0, seen: 1'b0, dec_ok: 1'b1};

  // outcome of one dotted decimal step
  typedef struct packed {
    logic       ok;
    token_t     tok;
    logic       we;
    logic [3:0] widx;
    logic [7:0] wdata;
  } dec_res_t;

  typedef struct packed {
    addr_bytes_t bytes;
    logic [4:0]  wpos;
    logic [4:0]  gap_pos;
    logic        gap_seen;
    logic [15:0] hex;
    logic        hex_seen;
    token_t      tok;
    logic        dotted;
    phase_e      phase;
    logic        err;
    logic [1:0]  family;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    bytes:    '0,
    wpos:     5'd0,
    gap_pos:  5'd0,
    gap_seen: 1'b0,
    hex:      16'd0,
    hex_seen: 1'b0,
    tok:      TokenReset,
    dotted:   1'b0,
    phase:    PhStart,
    err:      1'b0,
    family:   FamIpv4
  };

  typedef struct packed {
    status_e     status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;

endpackage

// File: hdl/ipp_in_if.sv
interface ipp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [1:0] family;

  modport source (output valid, output char_code, output family, input ready);
  modport sink (input valid, input char_code, input family, output ready);
endinterface

// File: hdl/ipp_out_if.sv
interface ipp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output status, output addr_high, output addr_low, input ready);
  modport sink (input valid, input status, input addr_high, input addr_low, output ready);
endinterface

// File: hdl/ipp_finish.sv
module ipp_finish (
  input  ipp_pkg::parse_state_t state_i,
  input  logic [1:0]            family_i,
  output ipp_pkg::result_t      result_o
);

  ipp_pkg::addr_bytes_t b;
  ipp_pkg::addr_bytes_t e;
  logic [4:0]           w;
  logic [4:0]           sh;
  logic [4:0]           src;
  logic                 ok;

  // close the last token, expand the gap and pack the address
  always_comb begin
    b  = state_i.bytes;
    e  = state_i.bytes;
    w  = state_i.wpos;
    sh = '0;
    src = '0;
    ok = !state_i.err;
    result_o.status    = ipp_pkg::StatusOk;
    result_o.addr_high = '0;
    result_o.addr_low  = '0;

    if (family_i[1]) begin
      result_o.status = ipp_pkg::StatusUnsupported;
    end else if (family_i == ipp_pkg::FamIpv4) begin
      if (state_i.tok.count < ipp_pkg::MaxOctets) ok = 1'b0;
      b[3] = state_i.tok.accum;
      if (ok) begin
        result_o.addr_low = {32'd0, b[0], b[1], b[2], b[3]};
      end else begin
        result_o.status = ipp_pkg::StatusMalformed;
      end
    end else begin
      if (state_i.phase == ipp_pkg::PhLead || state_i.phase == ipp_pkg::PhGroupColon) begin
        ok = 1'b0;
      end
      // last token: dotted tail or a pending hex group
      if (state_i.dotted) begin
        if (state_i.tok.count < ipp_pkg::MaxOctets) ok = 1'b0;
        b[w[3:0] + 4'd3] = state_i.tok.accum;
        w = w + 5'd4;
      end else if (state_i.hex_seen) begin
        if (w > ipp_pkg::GroupLastPos) begin
          ok = 1'b0;
        end else begin
          b[w[3:0]]        = state_i.hex[15:8];
          b[w[3:0] + 4'd1] = state_i.hex[7:0];
          w = w + 5'd2;
        end
      end
      e = b;
      // move the bytes after the gap to the end of the address
      if (state_i.gap_seen) begin
        if (w == ipp_pkg::FullPos) ok = 1'b0;
        sh = ipp_pkg::FullPos - w;
        for (int k = 0; k < ipp_pkg::NumBytes; k++) begin
          src = 5'(k) - sh;
          if (5'(k) < state_i.gap_pos) begin
            e[k] = b[k];
          end else if (5'(k) >= state_i.gap_pos + sh) begin
            e[k] = b[src[3:0]];
          end else begin
            e[k] = 8'd0;
          end
        end
        w = ipp_pkg::FullPos;
      end
      if (w != ipp_pkg::FullPos) ok = 1'b0;
      if (ok) begin
        for (int i = 0; i < ipp_pkg::NumBytes / 2; i++) begin
          result_o.addr_high[63 - 8*i -: 8] = e[i];
          result_o.addr_low[63 - 8*i -: 8]  = e[i + ipp_pkg::NumBytes / 2];
        end
      end else begin
        result_o.status = ipp_pkg::StatusMalformed;
      end
    end
  end

endmodule

// File: hdl/ip_address_text_parser_core.sv
// IP address text parser for dotted IPv4 and colon-hex IPv6 text.
// char_i carries one text byte per transaction with its family code; a
// byte of zero ends the string. The family is sampled with the first
// byte of each string. result_o carries one transaction per string end:
// status (valid, malformed, unsupported family) and the 128-bit address
// as addr_high/addr_low; an IPv4 address sits in the low 32 bits.
// Each byte is parsed in the cycle it is taken, so one byte per cycle is
// sustained while result_o is not stalled; the parse state registers are
// the only loop. The result of a terminator shows on result_o in the cycle
// after it is taken, from an output register that the final gap expansion
// mux feeds. While a result waits in that register char_i stays ready if
// result_o is ready in the same cycle; a stalled result_o holds char_i off
// until taken. Errors are kept until the terminator; after each result all
// parse state but the family returns to its start value. Reset empties the
// output register and starts a new string; no clearing pass is needed.
module ip_address_text_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipp_in_if.sink    char_i,
  ipp_out_if.source result_o
);

  ipp_pkg::parse_state_t state_q, state_d;
  ipp_pkg::result_t      res_q, res_d;
  ipp_pkg::dec_res_t     dr;
  logic                  out_valid_q;
  logic                  accept;
  logic                  first;
  logic                  is_end;
  logic [1:0]            fam;
  logic [7:0]            ch;
  logic                  hex_is;
  logic [3:0]            hex_val;

  // one step of dotted decimal parsing
  function automatic ipp_pkg::dec_res_t dec_step(input logic [7:0] c,
                                                 input ipp_pkg::token_t t,
                                                 input logic [4:0] wpos);
    ipp_pkg::dec_res_t r;
    logic [11:0]       n;
    r       = '0;
    r.tok   = t;
    r.wdata = t.accum;
    r.widx  = wpos[3:0] + {1'b0, t.count} - 4'd1;
    n = {1'b0, t.accum, 3'b000} + {3'b000, t.accum, 1'b0} + {8'd0, c[3:0]};
    if (c >= ipp_pkg::CharZero && c <= ipp_pkg::CharNine) begin
      if (t.seen && t.accum == 8'd0) begin
        r.ok = 1'b0;
      end else if (n[11:8] != 4'd0) begin
        r.ok = 1'b0;
      end else begin
        r.tok.accum = n[7:0];
        r.ok = 1'b1;
        if (!t.seen) begin
          r.tok.count = t.count + 3'd1;
          r.tok.seen  = 1'b1;
          r.ok = (r.tok.count <= ipp_pkg::MaxOctets);
        end
      end
    end else if (c == ipp_pkg::CharDot && t.seen) begin
      if (t.count != ipp_pkg::MaxOctets) begin
        r.ok        = 1'b1;
        r.we        = 1'b1;
        r.tok.accum = 8'd0;
        r.tok.seen  = 1'b0;
      end
    end
    return r;
  endfunction

  assign ch     = char_i.char_code;
  assign accept = char_i.valid && char_i.ready;
  assign first  = (state_q.phase == ipp_pkg::PhStart);
  assign is_end = (ch == ipp_pkg::CharNul);
  assign fam    = first ? char_i.family : state_q.family;
  assign dr     = dec_step(ch, state_q.tok, state_q.wpos);

  // hex digit decode, either case
  always_comb begin
    hex_is  = 1'b1;
    hex_val = ch[3:0];
    if (ch >= ipp_pkg::CharZero && ch <= ipp_pkg::CharNine) begin
      hex_val = ch[3:0];
    end else if ((ch >= ipp_pkg::CharLowA && ch <= ipp_pkg::CharLowF) ||
                 (ch >= ipp_pkg::CharUpA && ch <= ipp_pkg::CharUpF)) begin
      hex_val = ch[3:0] + 4'd9;
    end else begin
      hex_is = 1'b0;
    end
  end

  // parse state update for one text byte
  always_comb begin
    state_d = state_q;
    if (accept) begin
      if (is_end) begin
        state_d        = ipp_pkg::StateReset;
        state_d.family = fam;
      end else begin
        state_d.family = fam;
        if (first) state_d.phase = ipp_pkg::PhBody;
        if (!state_q.err && !fam[1]) begin
          if (fam == ipp_pkg::FamIpv4) begin
            state_d.tok = dr.tok;
            if (dr.we) state_d.bytes[dr.widx] = dr.wdata;
            state_d.err = !dr.ok;
          end else if (first && ch == ipp_pkg::CharColon) begin
            state_d.phase = ipp_pkg::PhLead;
          end else if (!first && state_q.phase == ipp_pkg::PhLead &&
                       ch != ipp_pkg::CharColon) begin
            state_d.err = 1'b1;
          end else begin
            state_d.phase = ipp_pkg::PhBody;
            if (state_q.dotted) begin
              // inside the dotted tail
              state_d.tok = dr.tok;
              if (dr.we) state_d.bytes[dr.widx] = dr.wdata;
              state_d.err = !dr.ok;
            end else if (hex_is) begin
              if (state_q.hex[15:12] != 4'd0) begin
                state_d.err = 1'b1;
              end else begin
                state_d.hex      = {state_q.hex[11:0], hex_val};
                state_d.hex_seen = 1'b1;
                if (state_q.tok.dec_ok) begin
                  state_d.tok        = dr.tok;
                  state_d.tok.dec_ok = dr.ok;
                end
              end
            end else if (ch == ipp_pkg::CharColon) begin
              if (!state_q.hex_seen) begin
                // start of the gap
                if (state_q.gap_seen) begin
                  state_d.err = 1'b1;
                end else begin
                  state_d.gap_seen = 1'b1;
                  state_d.gap_pos  = state_q.wpos;
                  state_d.tok      = ipp_pkg::TokenReset;
                end
              end else begin
                // close a hex group
                state_d.phase = ipp_pkg::PhGroupColon;
                if (state_q.wpos > ipp_pkg::GroupLastPos) begin
                  state_d.err = 1'b1;
                end else begin
                  state_d.bytes[state_q.wpos[3:0]]        = state_q.hex[15:8];
                  state_d.bytes[state_q.wpos[3:0] + 4'd1] = state_q.hex[7:0];
                  state_d.wpos     = state_q.wpos + 5'd2;
                  state_d.hex      = 16'd0;
                  state_d.hex_seen = 1'b0;
                  state_d.tok      = ipp_pkg::TokenReset;
                end
              end
            end else if (ch == ipp_pkg::CharDot) begin
              // switch the token to a dotted tail
              if (state_q.wpos > ipp_pkg::TailLastPos || !state_q.tok.dec_ok || !dr.ok) begin
                state_d.err = 1'b1;
              end else begin
                state_d.tok = dr.tok;
                if (dr.we) state_d.bytes[dr.widx] = dr.wdata;
                state_d.dotted   = 1'b1;
                state_d.hex_seen = 1'b0;
                state_d.hex      = 16'd0;
              end
            end else begin
              state_d.err = 1'b1;
            end
          end
        end
      end
    end
  end

  ipp_finish u_finish (
    .state_i  (state_q),
    .family_i (fam),
    .result_o (res_d)
  );

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipp_pkg::StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && is_end) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_end) begin
      res_q <= res_d;
    end
  end

  assign char_i.ready       = !out_valid_q || result_o.ready;
  assign result_o.valid     = out_valid_q;
  assign result_o.status    = res_q.status;
  assign result_o.addr_high = res_q.addr_high;
  assign result_o.addr_low  = res_q.addr_low;

endmodule

// File: hdl/ipp_checker.sv
module ipp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [7:0]  char_code_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [63:0] addr_high_i,
  input logic [63:0] addr_low_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(addr_high_i) && $stable(addr_low_i))
    else $error("result changed while stalled");

  // a terminator yields a result in the next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && char_code_i == ipp_pkg::CharNul |=> out_valid_i)
    else $error("terminator gave no result");

  // ordinary text bytes never make a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && char_code_i != ipp_pkg::CharNul && !out_valid_i |=> !out_valid_i)
    else $error("result without terminator");

  // failed parses carry a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ipp_pkg::StatusOk |-> addr_high_i == 64'd0 &&
    addr_low_i == 64'd0)
    else $error("nonzero address on failure");

endmodule

bind ip_address_text_parser_core ipp_checker u_ipp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (char_i.valid),
  .in_ready_i  (char_i.ready),
  .char_code_i (char_i.char_code),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .status_i    (result_o.status),
  .addr_high_i (result_o.addr_high),
  .addr_low_i  (result_o.addr_low)
);

// File: test/ipp_result_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts each result from the accepted text and
// compares it field by field with what the parser delivers
module ipp_result_checker
  import ipp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ipp_in_if    char_mon,
  ipp_out_if   res_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // predicted parse state
  logic [7:0]  addr_b [NumBytes];
  int unsigned wr_pos;
  int unsigned gap_at;
  bit          gap_on;
  int unsigned hex_acc;
  bit          hex_on;
  int unsigned oct_acc;
  int unsigned oct_num;
  bit          oct_on;
  bit          tok_dec_ok;
  bit          dotted;
  phase_e      parse_ph;
  bit          err_on;
  logic [1:0]  fam_q;

  result_t pending_results[$];
  result_t new_result;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void reset_token();
    oct_acc    = 0;
    oct_num    = 0;
    oct_on     = 0;
    tok_dec_ok = 1;
  endfunction

  function automatic void clear_parse();
    for (int i = 0; i < NumBytes; i++) addr_b[i] = 8'd0;
    wr_pos   = 0;
    gap_at   = 0;
    gap_on   = 0;
    hex_acc  = 0;
    hex_on   = 0;
    dotted   = 0;
    reset_token();
    parse_ph = PhStart;
    err_on   = 0;
  endfunction

  // dotted decimal step, octets land at wr_pos onward
  function automatic bit octet_step(input logic [7:0] ch);
    int unsigned n;
    if (ch >= CharZero && ch <= CharNine) begin
      n = oct_acc * 10 + int'(ch - CharZero);
      if (oct_on && oct_acc == 0) return 0;
      if (n > 255) return 0;
      oct_acc = n;
      if (!oct_on) begin
        oct_num++;
        if (oct_num > MaxOctets) return 0;
        oct_on = 1;
      end
      return 1;
    end
    if (ch == CharDot && oct_on) begin
      if (oct_num == MaxOctets) return 0;
      addr_b[(wr_pos + oct_num - 1) & 15] = oct_acc[7:0];
      oct_acc = 0;
      oct_on  = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit octet_finish();
    if (oct_num < MaxOctets) return 0;
    addr_b[(wr_pos + 3) & 15] = oct_acc[7:0];
    return 1;
  endfunction

  function automatic int hex_val(input logic [7:0] ch);
    if (ch >= CharZero && ch <= CharNine) return int'(ch - CharZero);
    if (ch >= CharLowA && ch <= CharLowF) return int'(ch - CharLowA) + 10;
    if (ch >= CharUpA && ch <= CharUpF) return int'(ch - CharUpA) + 10;
    return -1;
  endfunction

  function automatic void put_group();
    addr_b[wr_pos & 15]       = hex_acc[15:8];
    addr_b[(wr_pos + 1) & 15] = hex_acc[7:0];
    wr_pos += 2;
  endfunction

  function automatic void v6_char(input logic [7:0] ch, input bit first);
    int h;
    if (first && ch == CharColon) begin
      parse_ph = PhLead;
      return;
    end
    // a leading colon must be doubled
    if (parse_ph == PhLead && ch != CharColon) begin
      err_on = 1;
      return;
    end
    parse_ph = PhBody;
    if (dotted) begin
      if (!octet_step(ch)) err_on = 1;
      return;
    end
    h = hex_val(ch);
    if (h >= 0) begin
      if ((hex_acc >> 12) != 0) begin
        err_on = 1;
        return;
      end
      hex_acc = ((hex_acc << 4) | h) & 16'hffff;
      hex_on  = 1;
      if (tok_dec_ok && !octet_step(ch)) tok_dec_ok = 0;
      return;
    end
    if (ch == CharColon) begin
      if (!hex_on) begin
        if (gap_on) begin
          err_on = 1;
          return;
        end
        gap_on = 1;
        gap_at = wr_pos;
      end else begin
        parse_ph = PhGroupColon;
        if (wr_pos + 2 > NumBytes) begin
          err_on = 1;
          return;
        end
        put_group();
        hex_acc = 0;
        hex_on  = 0;
      end
      reset_token();
      return;
    end
    // start of a dotted tail
    if (ch == CharDot) begin
      if (wr_pos + 4 > NumBytes || !tok_dec_ok || !octet_step(ch)) begin
        err_on = 1;
        return;
      end
      dotted  = 1;
      hex_on  = 0;
      hex_acc = 0;
      return;
    end
    err_on = 1;
  endfunction

  function automatic bit v6_finish();
    int unsigned n;
    int unsigned src;
    if (parse_ph == PhLead || parse_ph == PhGroupColon) return 0;
    if (dotted) begin
      if (!octet_finish()) return 0;
      wr_pos += 4;
    end else if (hex_on) begin
      if (wr_pos + 2 > NumBytes) return 0;
      put_group();
    end
    // gap expansion: bytes after the gap move to the end
    if (gap_on) begin
      if (wr_pos == NumBytes) return 0;
      n = wr_pos - gap_at;
      for (int unsigned i = 1; i <= n; i++) begin
        src = (gap_at + n - i) & 15;
        addr_b[(NumBytes - i) & 15] = addr_b[src];
        addr_b[src] = 8'd0;
      end
      wr_pos = NumBytes;
    end
    return wr_pos == NumBytes;
  endfunction

  // advances the predicted state by one character, returns 1 with a result
  function automatic bit parse_char(input logic [7:0] ch, input logic [1:0] fm,
                                    output result_t res);
    bit          first;
    bit          ok;
    logic [63:0] hi;
    logic [63:0] lo;
    first = 0;
    hi    = '0;
    lo    = '0;
    res   = '0;
    if (parse_ph == PhStart) begin
      fam_q = fm;
      first = 1;
    end
    if (ch != CharNul) begin
      if (first) parse_ph = PhBody;
      if (err_on || fam_q[1]) return 0;
      if (fam_q == FamIpv4) begin
        if (!octet_step(ch)) err_on = 1;
      end else begin
        v6_char(ch, first);
      end
      return 0;
    end
    // terminator
    if (fam_q[1]) begin
      res.status = StatusUnsupported;
    end else begin
      ok = !err_on;
      if (ok) ok = (fam_q == FamIpv4) ? octet_finish() : v6_finish();
      if (ok && fam_q == FamIpv4) begin
        for (int i = 0; i < 4; i++) lo = {lo[55:0], addr_b[i]};
      end else if (ok) begin
        for (int i = 0; i < 8; i++) begin
          hi = {hi[55:0], addr_b[i]};
          lo = {lo[55:0], addr_b[i + 8]};
        end
      end
      res.status = ok ? StatusOk : StatusMalformed;
    end
    res.addr_high = hi;
    res.addr_low  = lo;
    clear_parse();
    return 1;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    fam_q        = FamIpv4;
    clear_parse();
  end

  // compare delivered results, then predict from accepted characters
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_mon.valid && res_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          new_result = pending_results.pop_front();
          if (res_mon.status !== new_result.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      res_mon.status, new_result.status));
          if (res_mon.addr_high !== new_result.addr_high)
            report_mismatch($sformatf("addr_high got %h exp %h",
                                      res_mon.addr_high, new_result.addr_high));
          if (res_mon.addr_low !== new_result.addr_low)
            report_mismatch($sformatf("addr_low got %h exp %h",
                                      res_mon.addr_low, new_result.addr_low));
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        if (parse_char(char_mon.char_code, char_mon.family, new_result))
          pending_results.push_back(new_result);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// File: test/tb_ip_address_text_parser_core.sv
`timescale 1ns / 1ps

module tb_ip_address_text_parser_core;
  import ipp_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam logic [1:0] FamBad2    = 2'd2;
  localparam logic [1:0] FamBad3    = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         DrainCycles = 20;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   chars_sent;
  int   strings_sent;

  ipp_in_if  char_bus ();
  ipp_out_if res_bus ();

  ip_address_text_parser_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .char_i  (char_bus),
    .result_o(res_bus)
  );

  ipp_result_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .char_mon    (char_bus),
    .res_mon     (res_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure
  initial res_bus.ready = 1'b0;
  always @(negedge clk) begin
    res_bus.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void push_str(ref text_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic logic [7:0] random_char();
    string alphabet;
    alphabet = "0123456789abcdefABCDEF:.g/ x";
    if ($urandom_range(1)) return alphabet[$urandom_range(alphabet.len() - 1)];
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic void push_octets(ref text_t t);
    int v;
    for (int i = 0; i < 4; i++) begin
      v = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom_range(255);
      if (i > 0) t.push_back(CharDot);
      push_str(t, $sformatf("%0d", v));
    end
  endfunction

  // one hex group, random case, sometimes zero padded, rarely too large
  function automatic void push_group(ref text_t t);
    int         v;
    string      s;
    logic [7:0] c;
    if ($urandom_range(63) == 0) v = $urandom_range(20'hfffff);
    else if ($urandom_range(1)) v = $urandom_range(16'hffff);
    else v = $urandom_range(15);
    s = ($urandom_range(3) == 0) ? $sformatf("%04h", v) : $sformatf("%0h", v);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= CharLowA && c <= CharLowF && $urandom_range(1)) c = c - 8'h20;
      t.push_back(c);
    end
  endfunction

  // well-formed ipv6 text: groups, optional gap, optional dotted tail
  function automatic text_t make_v6();
    text_t t;
    bit    tail;
    bit    gap;
    int    words;
    int    k;
    int    split;
    tail  = ($urandom_range(3) == 0);
    words = tail ? 6 : 8;
    gap   = ($urandom_range(9) < 6);
    k     = gap ? $urandom_range(words - 1) : words;
    split = gap ? $urandom_range(k) : k;
    for (int i = 0; i < split; i++) begin
      if (i > 0) t.push_back(CharColon);
      push_group(t);
    end
    if (gap) begin
      t.push_back(CharColon);
      t.push_back(CharColon);
    end
    for (int i = split; i < k; i++) begin
      if (i > split) t.push_back(CharColon);
      push_group(t);
    end
    if (tail) begin
      if (t.size() > 0 && t[t.size() - 1] != CharColon) t.push_back(CharColon);
      push_octets(t);
    end
    return t;
  endfunction

  // one random edit: replace, delete, insert, or extra colon
  function automatic void mutate(ref text_t t);
    int op;
    int pos;
    op = (t.size() == 0) ? 2 : $urandom_range(3);
    case (op)
      0: begin
        pos = $urandom_range(t.size() - 1);
        t[pos] = random_char();
      end
      1: begin
        pos = $urandom_range(t.size() - 1);
        t.delete(pos);
      end
      2: begin
        pos = $urandom_range(t.size());
        t.insert(pos, random_char());
      end
      default: begin
        pos = $urandom_range(t.size());
        t.insert(pos, CharColon);
      end
    endcase
  endfunction

  function automatic text_t make_noise();
    text_t t;
    int    len;
    len = $urandom_range(12);
    for (int i = 0; i < len; i++) t.push_back(random_char());
    return t;
  endfunction

  // sends a string and its terminator; family rides on the first transaction,
  // later transactions carry a random family that must be ignored
  task automatic send_string(input text_t txt, input logic [1:0] fam);
    logic [7:0] ch;
    for (int k = 0; k <= txt.size(); k++) begin
      ch = (k < txt.size()) ? txt[k] : CharNul;
      while ($urandom_range(99) < tx_idle_pct) begin
        char_bus.valid <= 1'b0;
        @(negedge clk);
      end
      char_bus.valid     <= 1'b1;
      char_bus.char_code <= ch;
      char_bus.family    <= (k == 0) ? fam : 2'($urandom_range(3));
      @(posedge clk);
      while (!char_bus.ready) @(posedge clk);
      @(negedge clk);
    end
    if (!fam[1]) chars_sent += txt.size() + 1;
    strings_sent++;
  endtask

  task automatic send_text(input string s, input logic [1:0] fam);
    text_t t;
    push_str(t, s);
    send_string(t, fam);
  endtask

  // stimulus and verdict
  initial begin
    text_t      t;
    logic [1:0] fm;
    int         sel;
    int         c0;
    int         s0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = CharNul;
    char_bus.family    = FamIpv4;
    tx_idle_pct  = 29;
    rx_idle_pct  = 72;
    chars_sent   = 0;
    strings_sent = 0;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: octet and group extremes, empty and unsupported strings,
    // colon and gap corner cases, dotted tails, stray bytes
    send_text("0.0.0.0", FamIpv4);
    send_text("255.255.255.255", FamIpv4);
    send_text("256.1.1.1", FamIpv4);
    send_text("1.02.3.4", FamIpv4);
    send_text("1.2.3", FamIpv4);
    send_text("1.2.3.4.5", FamIpv4);
    send_text("", FamIpv4);
    send_text("", FamIpv6);
    send_text("", FamBad2);
    send_text("::", FamBad3);
    send_text("1.2.3.4", FamBad2);
    send_text("::", FamIpv6);
    send_text("::1", FamIpv6);
    send_text(":1::", FamIpv6);
    send_text("1:2:3:4:5:6:7:", FamIpv6);
    send_text("1::2::3", FamIpv6);
    send_text("1:2:3:4:5:6:7:8::", FamIpv6);
    send_text("ffff:FFFF:abcd:ABCD:0:9:00aB:fFfF", FamIpv6);
    send_text("12345::1", FamIpv6);
    send_text("0000f::", FamIpv6);
    send_text("::ffff:192.168.0.255", FamIpv6);
    send_text("1:2:3:4:5:6:7:1.2.3.4", FamIpv6);
    send_text("1:2:3:4:5:6:255.0.0.1", FamIpv6);
    send_text("1:2::01.2.3.4", FamIpv6);
    t = {};
    push_str(t, "10.0.0.");
    t.push_back(8'hb5);
    send_string(t, FamIpv4);

    // random: three idle settings, mostly well-formed text
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      c0 = chars_sent;
      s0 = strings_sent;
      while (chars_sent - c0 < 75 || strings_sent - s0 < 4) begin
        sel = $urandom_range(99);
        t   = {};
        if (sel < 35) begin
          push_octets(t);
          fm = FamIpv4;
        end else if (sel < 70) begin
          t  = make_v6();
          fm = FamIpv6;
        end else if (sel < 88) begin
          if ($urandom_range(1)) begin
            push_octets(t);
            fm = FamIpv4;
          end else begin
            t  = make_v6();
            fm = FamIpv6;
          end
          mutate(t);
          if ($urandom_range(4) == 0) fm = fm ^ 2'd1;
        end else if (sel < 95) begin
          t  = make_noise();
          fm = 2'($urandom_range(1));
        end else begin
          if ($urandom_range(1)) push_octets(t);
          else t = make_noise();
          fm = 2'($urandom_range(3, 2));
        end
        send_string(t, fm);
      end
    end
    char_bus.valid <= 1'b0;

    // drain
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
